// File: rtl/pva_pkg.sv
package pva_pkg;

  // Fixed widths of the words on the ports.
  localparam int CMD_W       = 1;
  localparam int SCENE_W     = 5;
  localparam int MODEL_W     = 7;
  localparam int ANGLE_W     = 16;
  localparam int SCORE_W     = 16;
  localparam int BIN_W       = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int BINS_REG_W  = 6;
  localparam int POINTS_REG_W = 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_VOTE  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_BINS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_POINTS = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [BINS_REG_W-1:0]   ANGLE_BINS_RST   = 6'd30;
  localparam logic [POINTS_REG_W-1:0] MODEL_POINTS_RST = 8'd128;

  // Sequencer states.
  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_VWR    = 6'b000100,
    S_QRD    = 6'b001000,
    S_QDRAIN = 6'b010000,
    S_QOUT   = 6'b100000
  } state_t;

endpackage

// File: rtl/pva_if.sv
interface pva_item_if;
  logic                          valid;
  logic                          ready;
  logic [pva_pkg::CMD_W-1:0]     cmd;
  logic [pva_pkg::SCENE_W-1:0]   scene_ref;
  logic [pva_pkg::MODEL_W-1:0]   model_ref;
  logic [pva_pkg::ANGLE_W-1:0]   model_angle;
  logic [pva_pkg::ANGLE_W-1:0]   scene_angle;

  modport source (output valid, cmd, scene_ref, model_ref, model_angle, scene_angle,
                  input ready);
  modport sink (input valid, cmd, scene_ref, model_ref, model_angle, scene_angle,
                output ready);
endinterface

interface pva_result_if;
  logic                          valid;
  logic                          ready;
  logic [pva_pkg::SCORE_W-1:0]   peak_score;
  logic [pva_pkg::MODEL_W-1:0]   peak_model_ref;
  logic [pva_pkg::BIN_W-1:0]     peak_angle_bin;

  modport source (output valid, peak_score, peak_model_ref, peak_angle_bin,
                  input ready);
  modport sink (input valid, peak_score, peak_model_ref, peak_angle_bin,
                output ready);
endinterface

interface pva_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pva_pkg::CFG_IDX_W-1:0]   index;
  logic [pva_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/pose_vote_accumulator.sv
// Vote word: accepted in S_IDLE and written back to the store in the next cycle, in S_VWR.
// Query word: the walk reads the nb*np counters in use (nb angle bins and np model references),
// one counter read per cycle on the single memory read port, then passes S_QDRAIN and S_QOUT.
// After reset the vote store is swept to zero, one word per cycle, over all
// 2^(clog2 scene refs + clog2 model refs + clog2 bins) words; no word is taken meanwhile.
// Configuration registers return to 30 angle bins and 128 model points at reset.
module pose_vote_accumulator #(
  parameter int SCENE_REFS  = 32,
  parameter int MODEL_REFS  = 128,
  parameter int MAX_BINS    = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  pva_item_if.sink            item,
  pva_result_if.source        result,
  pva_cfg_if.sink             cfg
);

  // Index widths of the three address fields. The store is addressed by the
  // concatenation {scene, model, bin}, so each field is a power-of-two slice.
  localparam int SW    = (SCENE_REFS > 1) ? $clog2(SCENE_REFS) : 1;
  localparam int MW    = (MODEL_REFS > 1) ? $clog2(MODEL_REFS) : 1;
  localparam int BW    = $clog2(MAX_BINS);
  localparam int AW    = SW + MW + BW;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = COUNT_WIDTH;

  localparam logic [8:0]  SCENE_LIM = 9'(SCENE_REFS);
  localparam logic [10:0] MODEL_LIM = 11'(MODEL_REFS);
  localparam logic [6:0]  BINS_LIM  = 7'(MAX_BINS);

  pva_pkg::state_t state;

  // Configuration registers. The port never stalls.
  logic [pva_pkg::BINS_REG_W-1:0]   angle_bins;
  logic [pva_pkg::POINTS_REG_W-1:0] model_points;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_bins   <= pva_pkg::ANGLE_BINS_RST;
      model_points <= pva_pkg::MODEL_POINTS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pva_pkg::CFG_ANGLE_BINS:   angle_bins   <= cfg.data[pva_pkg::BINS_REG_W-1:0];
        pva_pkg::CFG_MODEL_POINTS: model_points <= cfg.data;
        default: ;
      endcase
    end
  end

  // Effective bin and point counts: zero reads as one, and values above the
  // built-in size are clamped to it.
  logic [6:0]  nb;
  logic [10:0] np;

  always_comb begin
    nb = 7'(angle_bins);
    if (nb == 7'd0) nb = 7'd1;
    if (nb > BINS_LIM) nb = BINS_LIM;
    np = 11'(model_points);
    if (np == 11'd0) np = 11'd1;
    if (np > MODEL_LIM) np = MODEL_LIM;
  end

  // Vote address. The angle difference wraps modulo one turn, and the bin is the
  // upper part of diff * nb, which is always below nb.
  logic [15:0]   diff;
  logic [22:0]   prod;
  logic [BW-1:0] bin_in;
  logic [8:0]    s_ext;
  logic [10:0]   m_ext;
  logic          s_ok;
  logic          m_ok;
  logic [AW-1:0] vote_addr;

  assign diff      = item.scene_angle - item.model_angle;
  assign prod      = 23'(diff) * 23'(nb);
  assign bin_in    = prod[16 +: BW];
  assign s_ext     = 9'(item.scene_ref);
  assign m_ext     = 11'(item.model_ref);
  assign s_ok      = (s_ext < SCENE_LIM);
  assign m_ok      = (m_ext < MODEL_LIM);
  assign vote_addr = {s_ext[SW-1:0], m_ext[MW-1:0], bin_in};

  logic accept;
  assign item.ready = (state == pva_pkg::S_IDLE);
  assign accept     = item.valid && item.ready;

  // Query walk counters: bin-major, model reference inner.
  logic [SW-1:0] qscene;
  logic [MW-1:0] m_cnt;
  logic [BW-1:0] b_cnt;
  logic          m_last;
  logic          b_last;

  assign m_last = (11'(m_cnt) == np - 11'd1);
  assign b_last = (7'(b_cnt) == nb - 7'd1);

  // Vote store with one read and one write port; read data is registered.
  logic [CW-1:0] mem [DEPTH];
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] rdata;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] wr_data;
  logic          wr_en;
  logic [AW-1:0] vaddr;
  logic [AW-1:0] clr_addr;
  logic [CW-1:0] inc_data;

  assign inc_data = (rdata == {CW{1'b1}}) ? rdata : rdata + CW'(1);

  always_comb begin
    rd_addr = vote_addr;
    if (state == pva_pkg::S_QRD) rd_addr = {qscene, m_cnt, b_cnt};
    wr_en   = (state == pva_pkg::S_CLEAR) || (state == pva_pkg::S_VWR);
    wr_addr = (state == pva_pkg::S_CLEAR) ? clr_addr : vaddr;
    wr_data = (state == pva_pkg::S_CLEAR) ? '0 : inc_data;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  // Compare stage: the tag is registered in step with each walk read, so it lines up with the read data.
  logic          tag_valid;
  logic [MW-1:0] tag_m;
  logic [BW-1:0] tag_b;
  logic [CW-1:0] best;
  logic [MW-1:0] best_m;
  logic [BW-1:0] best_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
    end else begin
      tag_valid <= (state == pva_pkg::S_QRD);
    end
    tag_m <= m_cnt;
    tag_b <= b_cnt;
    if (accept) begin
      // Starting from zero at the first entry matches a first-entry-wins walk.
      best   <= '0;
      best_m <= '0;
      best_b <= '0;
    end else if (tag_valid && (rdata > best)) begin
      best   <= rdata;
      best_m <= tag_m;
      best_b <= tag_b;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pva_pkg::S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        pva_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == {AW{1'b1}}) state <= pva_pkg::S_IDLE;
        end
        pva_pkg::S_IDLE: begin
          if (accept) begin
            if (item.cmd == pva_pkg::CMD_VOTE) begin
              if (s_ok && m_ok) state <= pva_pkg::S_VWR;
            end else if (s_ok) begin
              state <= pva_pkg::S_QRD;
            end else begin
              state <= pva_pkg::S_QOUT;
            end
          end
        end
        pva_pkg::S_VWR: state <= pva_pkg::S_IDLE;
        pva_pkg::S_QRD: begin
          if (m_last && b_last) state <= pva_pkg::S_QDRAIN;
        end
        pva_pkg::S_QDRAIN: state <= pva_pkg::S_QOUT;
        pva_pkg::S_QOUT: begin
          if (!result.valid || result.ready) state <= pva_pkg::S_IDLE;
        end
        default: state <= pva_pkg::S_IDLE;
      endcase
    end
  end

  // Walk address registers and vote address hold.
  always_ff @(posedge clk) begin
    if (accept) begin
      vaddr  <= vote_addr;
      qscene <= s_ext[SW-1:0];
      m_cnt  <= '0;
      b_cnt  <= '0;
    end else if (state == pva_pkg::S_QRD) begin
      if (m_last) begin
        m_cnt <= '0;
        b_cnt <= b_cnt + BW'(1);
      end else begin
        m_cnt <= m_cnt + MW'(1);
      end
    end
  end

  // Result register. A score wider than the port saturates.
  logic [31:0] best32;
  logic [10:0] best_m_ext;
  logic [6:0]  best_b_ext;

  assign best32     = 32'(best);
  assign best_m_ext = 11'(best_m);
  assign best_b_ext = 7'(best_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == pva_pkg::S_QOUT && (!result.valid || result.ready)) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
    if (state == pva_pkg::S_QOUT && (!result.valid || result.ready)) begin
      result.peak_score     <= (best32 > 32'h0000_FFFF) ? 16'hFFFF : best32[15:0];
      result.peak_model_ref <= best_m_ext[pva_pkg::MODEL_W-1:0];
      result.peak_angle_bin <= best_b_ext[pva_pkg::BIN_W-1:0];
    end
  end

  // A valid vote always goes on to its write-back cycle.
  a_vote_wb: assert property (@(posedge clk) disable iff (rst)
    accept && item.cmd == pva_pkg::CMD_VOTE && s_ok && m_ok |=> state == pva_pkg::S_VWR)
    else $error("valid vote did not reach write-back");

  // An increment never wraps a counter back to zero.
  a_no_wrap: assert property (@(posedge clk) disable iff (rst)
    state == pva_pkg::S_VWR |-> wr_data != '0)
    else $error("vote counter wrapped");

  // A result appears only from the output state of the sequencer.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == pva_pkg::S_QOUT))
    else $error("result raised outside output state");

  // No word is taken while the store is being cleared.
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    state == pva_pkg::S_CLEAR |-> !item.ready)
    else $error("word accepted during clear");

  // The walk stays inside the bins and points in use.
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    state == pva_pkg::S_QRD |-> (7'(b_cnt) < nb) && (11'(m_cnt) < np))
    else $error("peak walk out of range");

endmodule
